### rtl/known_register_value_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// known register value tracker assertion macros
// shared concurrent assertion forms used at the top level
// ----------------------------------------------------------------------------
`ifndef KNOWN_REGISTER_VALUE_TRACKER_TOP_MACROS_SVH
`define KNOWN_REGISTER_VALUE_TRACKER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define KRVT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define KRVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/krvt_pkg.sv
// ----------------------------------------------------------------------------
// krvt_pkg
// types and codes shared by the known register value tracker
// ----------------------------------------------------------------------------
package krvt_pkg;

   // instruction classes
   localparam logic [4:0] OP_OTHER = 5'd0;
   localparam logic [4:0] OP_CLC   = 5'd1;
   localparam logic [4:0] OP_SEC   = 5'd2;
   localparam logic [4:0] OP_BCS   = 5'd3;
   localparam logic [4:0] OP_BCC   = 5'd4;
   localparam logic [4:0] OP_DEY   = 5'd5;
   localparam logic [4:0] OP_DEX   = 5'd6;
   localparam logic [4:0] OP_INY   = 5'd7;
   localparam logic [4:0] OP_INX   = 5'd8;
   localparam logic [4:0] OP_TXA   = 5'd9;
   localparam logic [4:0] OP_TYA   = 5'd10;
   localparam logic [4:0] OP_TAX   = 5'd11;
   localparam logic [4:0] OP_TAY   = 5'd12;
   localparam logic [4:0] OP_LDA   = 5'd13;
   localparam logic [4:0] OP_LDX   = 5'd14;
   localparam logic [4:0] OP_LDY   = 5'd15;
   localparam logic [4:0] OP_CLD   = 5'd16;
   localparam logic [4:0] OP_SED   = 5'd17;
   localparam logic [4:0] OP_ADC   = 5'd18;
   localparam logic [4:0] OP_SBC   = 5'd19;

   // register codes for dest_reg and rewrite_target
   localparam logic [1:0] REG_NONE = 2'd0;
   localparam logic [1:0] REG_A    = 2'd1;
   localparam logic [1:0] REG_X    = 2'd2;
   localparam logic [1:0] REG_Y    = 2'd3;

   // bit positions in the known mask
   localparam int KB_A = 0;
   localparam int KB_X = 1;
   localparam int KB_Y = 2;
   localparam int KB_C = 3;
   localparam int KB_D = 4;

   typedef struct packed {
      logic       start_block;
      logic [4:0] op_class;
      logic [1:0] dest_reg;
      logic       alters_carry;
      logic       immediate_mode;
      logic       dynamic_operand;
      logic       indirect_y_mode;
      logic [7:0] operand;
      logic       exits_block;
   } req_word_type;

   typedef struct packed {
      logic [4:0] known_mask;
      logic [7:0] a_value;
      logic [7:0] x_value;
      logic [7:0] y_value;
      logic       carry_value;
      logic       decimal_value;
      logic       drop_bcd_check;
      logic       drop_carry_load;
      logic [1:0] rewrite_target;
      logic [7:0] rewrite_value;
      logic       constant_y_index;
   } rsp_word_type;

   // pipeline control between the stages
   typedef struct packed {
      logic held_valid;
      logic advance;
   } stage_ctl_type;

endpackage

### rtl/krvt_if.sv
// ----------------------------------------------------------------------------
// krvt_req_if / krvt_rsp_if
// valid/ready channels carrying instruction and result words
// ----------------------------------------------------------------------------
interface krvt_req_if import krvt_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface krvt_rsp_if import krvt_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/krvt_in_stage.sv
// ----------------------------------------------------------------------------
// krvt_in_stage
// input register holding one instruction word until the core takes it
// ----------------------------------------------------------------------------
module krvt_in_stage import krvt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   krvt_req_if.sink      req_port,
   input  stage_ctl_type ctl,
   output logic          held_valid,
   output req_word_type  held_word
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         take;

   // room when empty or when the held word moves on this cycle
   assign req_port.ready = !valid_ff || ctl.advance;
   assign take           = req_port.valid && req_port.ready;

   // occupancy
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (ctl.advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_port.data;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

### rtl/krvt_core.sv
// ----------------------------------------------------------------------------
// krvt_core
// tracked register knowledge, rewrite choices and per-instruction update
// ----------------------------------------------------------------------------
module krvt_core import krvt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  req_word_type  word,
   output rsp_word_type  result
);

   logic [4:0] known_ff, known_in;
   logic [7:0] acc_ff, acc_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic       carry_ff, carry_in;
   logic       dec_ff, dec_in;
   logic       bcd_ff, bcd_in;

   logic [4:0] kb;
   logic [7:0] a_s, x_s, y_s;
   logic       c_s, d_s, bcd_s;
   logic [7:0] a_v, x_v, y_v;
   logic       c_v, d_v;
   logic       konst;
   logic       carry_match;

   // state as seen by this instruction, a block start wipes it
   always_comb begin
      if (word.start_block) begin
         kb    = '0;
         a_s   = '0;
         x_s   = '0;
         y_s   = '0;
         c_s   = 1'b0;
         d_s   = 1'b0;
         bcd_s = 1'b0;
      end else begin
         kb    = known_ff;
         a_s   = acc_ff;
         x_s   = x_ff;
         y_s   = y_ff;
         c_s   = carry_ff;
         d_s   = dec_ff;
         bcd_s = bcd_ff;
      end
   end

   // reported values are zero unless known
   assign a_v = kb[KB_A] ? a_s : 8'd0;
   assign x_v = kb[KB_X] ? x_s : 8'd0;
   assign y_v = kb[KB_Y] ? y_s : 8'd0;
   assign c_v = kb[KB_C] ? c_s : 1'b0;
   assign d_v = kb[KB_D] ? d_s : 1'b0;

   // adc wants carry clear, sbc wants carry set
   assign carry_match = (word.op_class == OP_SBC) ? c_v : !c_v;
   assign konst       = word.immediate_mode && !word.dynamic_operand;

   // rewrite choices from knowledge before the instruction
   always_comb begin
      result                  = '0;
      result.known_mask       = kb;
      result.a_value          = a_v;
      result.x_value          = x_v;
      result.y_value          = y_v;
      result.carry_value      = c_v;
      result.decimal_value    = d_v;
      bcd_in                  = bcd_s;
      if (!word.exits_block) begin
         case (word.op_class)
            OP_ADC, OP_SBC: begin
               result.drop_bcd_check  = (kb[KB_D] && !d_v) || bcd_s;
               result.drop_carry_load = kb[KB_C] && carry_match;
               bcd_in                 = 1'b1;
            end
            OP_DEY: if (kb[KB_Y]) begin
               result.rewrite_target = REG_Y;
               result.rewrite_value  = y_v - 8'd1;
            end
            OP_DEX: if (kb[KB_X]) begin
               result.rewrite_target = REG_X;
               result.rewrite_value  = x_v - 8'd1;
            end
            OP_INY: if (kb[KB_Y]) begin
               result.rewrite_target = REG_Y;
               result.rewrite_value  = y_v + 8'd1;
            end
            OP_INX: if (kb[KB_X]) begin
               result.rewrite_target = REG_X;
               result.rewrite_value  = x_v + 8'd1;
            end
            OP_TXA: if (kb[KB_X]) begin
               result.rewrite_target = REG_A;
               result.rewrite_value  = x_v;
            end
            OP_TYA: if (kb[KB_Y]) begin
               result.rewrite_target = REG_A;
               result.rewrite_value  = y_v;
            end
            OP_TAX: if (kb[KB_A]) begin
               result.rewrite_target = REG_X;
               result.rewrite_value  = a_v;
            end
            OP_TAY: if (kb[KB_A]) begin
               result.rewrite_target = REG_Y;
               result.rewrite_value  = a_v;
            end
            default: begin
            end
         endcase
         result.constant_y_index = word.indirect_y_mode && kb[KB_Y];
      end
   end

   // knowledge update
   always_comb begin
      known_in = kb;
      acc_in   = a_s;
      x_in     = x_s;
      y_in     = y_s;
      carry_in = c_s;
      dec_in   = d_s;
      case (word.op_class)
         OP_CLC, OP_BCS: begin
            carry_in       = 1'b0;
            known_in[KB_C] = 1'b1;
         end
         OP_SEC, OP_BCC: begin
            carry_in       = 1'b1;
            known_in[KB_C] = 1'b1;
         end
         OP_DEY: y_in = y_s - 8'd1;
         OP_DEX: x_in = x_s - 8'd1;
         OP_INY: y_in = y_s + 8'd1;
         OP_INX: x_in = x_s + 8'd1;
         OP_TXA: begin
            acc_in         = x_s;
            known_in[KB_A] = kb[KB_X];
         end
         OP_TYA: begin
            acc_in         = y_s;
            known_in[KB_A] = kb[KB_Y];
         end
         OP_TAX: begin
            x_in           = a_s;
            known_in[KB_X] = kb[KB_A];
         end
         OP_TAY: begin
            y_in           = a_s;
            known_in[KB_Y] = kb[KB_A];
         end
         OP_LDA: begin
            if (konst) begin
               acc_in = word.operand;
            end
            known_in[KB_A] = konst;
         end
         OP_LDX: begin
            if (konst) begin
               x_in = word.operand;
            end
            known_in[KB_X] = konst;
         end
         OP_LDY: begin
            if (konst) begin
               y_in = word.operand;
            end
            known_in[KB_Y] = konst;
         end
         OP_CLD: begin
            dec_in         = 1'b0;
            known_in[KB_D] = 1'b1;
         end
         OP_SED: begin
            dec_in         = 1'b1;
            known_in[KB_D] = 1'b1;
         end
         default: begin
            case (word.dest_reg)
               REG_A:   known_in[KB_A] = 1'b0;
               REG_X:   known_in[KB_X] = 1'b0;
               REG_Y:   known_in[KB_Y] = 1'b0;
               default: begin
               end
            endcase
            if (word.alters_carry) begin
               known_in[KB_C] = 1'b0;
            end
         end
      endcase
   end

   // tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
         acc_ff   <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         carry_ff <= 1'b0;
         dec_ff   <= 1'b0;
         bcd_ff   <= 1'b0;
      end else if (ctl.advance) begin
         known_ff <= known_in;
         acc_ff   <= acc_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         carry_ff <= carry_in;
         dec_ff   <= dec_in;
         bcd_ff   <= bcd_in;
      end
   end

endmodule

### rtl/krvt_out_stage.sv
// ----------------------------------------------------------------------------
// krvt_out_stage
// result register, refills in the cycle its word is taken
// ----------------------------------------------------------------------------
module krvt_out_stage import krvt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  rsp_word_type  result,
   output logic          space,
   krvt_rsp_if.source    rsp_port
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign space = !valid_ff || rsp_port.ready;

   // occupancy
   always_comb begin
      valid_in = valid_ff;
      if (ctl.advance) begin
         valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         word_ff <= result;
      end
   end

   assign rsp_port.valid = valid_ff;
   assign rsp_port.data  = word_ff;

endmodule

### rtl/known_register_value_tracker_top.sv
// ----------------------------------------------------------------------------
// known_register_value_tracker_top
// tracks statically known 6502 register and flag values over a block
// ----------------------------------------------------------------------------
// One decoded instruction word is taken per clock while rsp ready stays high,
// and one result word comes out per instruction. An accepted word waits in
// the input register until the result register has room, then its result is
// loaded into the result register and presented from there until it is taken.
// Sustained rate is one instruction per cycle while rsp ready stays high: the
// result register refills in the cycle its word is taken, and the only loop
// is the update of the tracked A, X, Y, carry and decimal knowledge between
// the input and result registers. While a result waits, one more instruction
// can be held, then req ready drops. Each result reports the knowledge as it
// stood before the instruction plus the rewrite choices it allows; a set
// start_block clears all knowledge first.
module known_register_value_tracker_top import krvt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   krvt_req_if.sink   req_port,
   krvt_rsp_if.source rsp_port
);

`include "known_register_value_tracker_top_macros.svh"

   stage_ctl_type ctl;
   logic          held_valid;
   req_word_type  held_word;
   rsp_word_type  result;
   logic          space;

   // a held word moves when the result register has room
   assign ctl.held_valid = held_valid;
   assign ctl.advance    = held_valid && space;

   krvt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .ctl        (ctl),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   krvt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .word   (held_word),
      .result (result)
   );

   krvt_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .result   (result),
      .space    (space),
      .rsp_port (rsp_port)
   );

   // checks
   `KRVT_ASSERT_NEXT(a_held_kept, clock, reset, ctl.held_valid && !ctl.advance, ctl.held_valid, "stalled instruction word lost")
   `KRVT_ASSERT_NEXT(a_advance_shows, clock, reset, ctl.advance, rsp_port.valid, "advanced word missing at result")
   `KRVT_ASSERT_NOW(a_no_target_zero, clock, reset, rsp_port.valid && (rsp_port.data.rewrite_target == REG_NONE), rsp_port.data.rewrite_value == 8'd0, "rewrite value set without target")
   `KRVT_ASSERT_NOW(a_unknown_y_index, clock, reset, rsp_port.valid && !rsp_port.data.known_mask[KB_Y], !rsp_port.data.constant_y_index && (rsp_port.data.y_value == 8'd0), "constant y used while y unknown")

endmodule
